// File: design/bfg_pkg.sv
package bfg_pkg;

  localparam int WIN_H_DEF     = 5;
  localparam int WIN_W_DEF     = 5;
  localparam int MAX_WIDTH_DEF = 1024;

  localparam int PIX_W     = 8;
  localparam int GEO_W     = 13;
  localparam int ROW_W     = 12;
  localparam int IW_W      = 11;
  localparam int SCALE_W   = 24;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int MAX_HEIGHT = 4096;

  localparam int ROM_DEPTH = 4096;
  localparam int ROM_AW    = 12;
  localparam int WT_W      = 16;
  localparam int NUM_W     = 32;
  localparam int DEN_W     = 24;
  localparam int DCNT_W    = 5;

  localparam logic [IW_W-1:0]    IMAGE_WIDTH_RST   = 11'd512;
  localparam logic [GEO_W-1:0]   IMAGE_HEIGHT_RST  = 13'd512;
  localparam logic [SCALE_W-1:0] SPATIAL_SCALE_RST = 24'd23237;
  localparam logic [SCALE_W-1:0] RANGE_SCALE_RST   = 24'd516;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_SPATIAL_SCALE,
    REG_RANGE_SCALE
  } cfg_reg_t;

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] pixel;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] filtered;
    logic             end_of_frame;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CREAD,
    ST_CWAIT,
    ST_TREAD,
    ST_TSQ,
    ST_TARG,
    ST_TROM,
    ST_TWT,
    ST_TACC,
    ST_DSTART,
    ST_DIV,
    ST_LOAD
  } state_t;

  typedef logic [WT_W-1:0] exp_rom_t [ROM_DEPTH];

  // exp(-1/256) in Q2.62 from the alternating series, terms through the fourteenth power.
  localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;
  localparam logic [63:0] T1  = Q62_ONE / 64'd256;
  localparam logic [63:0] T2  = T1 / 64'd512;
  localparam logic [63:0] T3  = T2 / 64'd768;
  localparam logic [63:0] T4  = T3 / 64'd1024;
  localparam logic [63:0] T5  = T4 / 64'd1280;
  localparam logic [63:0] T6  = T5 / 64'd1536;
  localparam logic [63:0] T7  = T6 / 64'd1792;
  localparam logic [63:0] T8  = T7 / 64'd2048;
  localparam logic [63:0] T9  = T8 / 64'd2304;
  localparam logic [63:0] T10 = T9 / 64'd2560;
  localparam logic [63:0] T11 = T10 / 64'd2816;
  localparam logic [63:0] T12 = T11 / 64'd3072;
  localparam logic [63:0] T13 = T12 / 64'd3328;
  localparam logic [63:0] T14 = T13 / 64'd3584;
  localparam logic [63:0] EXP_STEP = Q62_ONE - T1 + T2 - T3 + T4 - T5 + T6 - T7
                                     + T8 - T9 + T10 - T11 + T12 - T13 + T14;

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ah, al, bh, bl, lo, mid;
    ah  = {32'd0, a[63:32]};
    al  = {32'd0, a[31:0]};
    bh  = {32'd0, b[63:32]};
    bl  = {32'd0, b[31:0]};
    lo  = al * bl;
    mid = ah * bl + al * bh;
    return ((ah * bh) << 2) + ((mid + (lo >> 32)) >> 30);
  endfunction

  // Entry k is round(65535 * exp(-k/256)).
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] v, p_hi, p_lo, q;
    v = Q62_ONE;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      p_hi   = (v >> 32) * 64'd65535;
      p_lo   = {32'd0, v[31:0]} * 64'd65535;
      q      = p_hi * 64'd4 + (p_lo >> 30);
      rom[k] = WT_W'((q + 64'h8000_0000) >> 32);
      v      = mul_q62(v, EXP_STEP);
    end
    return rom;
  endfunction

endpackage

// File: design/bilateral_filter_gray_unit.sv
// An accepted item that releases a result passes the readiness check, a centre read,
// then a tap loop over the T in-image taps of the clipped window
// (line store read, squares, two exponential lookups, weight product, accumulate)
// and a 32-step divider before it is loaded into the output register.
// in_stall is high outside ST_IDLE, so a new item waits until the last one is through.
// Reset is synchronous; it resets control state, configuration and positions, not the line store.
module bilateral_filter_gray_unit #(
  parameter int WIN_H     = bfg_pkg::WIN_H_DEF,
  parameter int WIN_W     = bfg_pkg::WIN_W_DEF,
  parameter int MAX_WIDTH = bfg_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bfg_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bfg_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [bfg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfg_pkg::CFG_W-1:0]      cfg_data
);
  import bfg_pkg::*;

  localparam int HALF_H   = (WIN_H - 1) / 2;
  localparam int HALF_W   = (WIN_W - 1) / 2;
  localparam int LS_ROWS  = WIN_H + 1;
  localparam int SLOT_W   = $clog2(LS_ROWS);
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int LS_DEPTH = LS_ROWS * MAX_WIDTH;
  localparam int LS_AW    = $clog2(LS_DEPTH);
  localparam int HALF_MAX = (HALF_H > HALF_W) ? HALF_H : HALF_W;
  localparam int OFF_W    = $clog2(HALF_MAX + 2);
  localparam int D2_W     = 2 * OFF_W + 1;
  localparam int SP_W     = SCALE_W + D2_W;
  localparam int RP_W     = SCALE_W + 2 * PIX_W;
  localparam int ACC_W    = WT_W + PIX_W;

  localparam exp_rom_t EXP_ROM = build_exp_rom();

  state_t state, state_next;

  logic [IW_W-1:0]    image_width;
  logic [GEO_W-1:0]   image_height;
  logic [SCALE_W-1:0] spatial_scale, range_scale;

  logic [ROW_W-1:0]  in_row, out_row;
  logic [COL_W-1:0]  in_col, out_col;
  logic [SLOT_W-1:0] in_slot, out_slot;
  logic              in_done;

  logic [GEO_W-1:0] eff_w, eff_h, w_last, h_last;

  // Line store and its read port.
  logic [PIX_W-1:0] ls_mem [LS_DEPTH];
  logic [PIX_W-1:0] ls_rdata;
  logic [LS_AW-1:0] ls_waddr, ls_raddr;
  logic             ls_we;

  // Tap loop.
  logic [ROW_W-1:0]  tr, r_last;
  logic [COL_W-1:0]  tc, c_first, c_last;
  logic [SLOT_W-1:0] t_slot;
  logic [PIX_W-1:0]  center, nb;
  logic [2*PIX_W-1:0] d2;
  logic [D2_W-1:0]   dist2;
  logic [SP_W-1:0]   sprod;
  logic [RP_W-1:0]   rprod;
  logic [WT_W-1:0]   ws_q, wr_q, ws_eff, wr_eff, wt;
  logic [NUM_W-1:0]  num, dq;
  logic [DEN_W-1:0]  den, rem;
  logic [DCNT_W-1:0] dcnt;

  logic in_acc, can_load, ready, tap_last;

  function automatic logic [LS_AW-1:0] ls_addr(input logic [SLOT_W-1:0] slot,
                                               input logic [COL_W-1:0] col);
    return LS_AW'(slot) * LS_AW'(MAX_WIDTH) + LS_AW'(col);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot);
    return (slot == SLOT_W'(LS_ROWS - 1)) ? '0 : slot + 1'b1;
  endfunction

  always_comb begin
    if (image_width == '0) begin
      eff_w = GEO_W'(1);
    end else if (GEO_W'(image_width) > GEO_W'(MAX_WIDTH)) begin
      eff_w = GEO_W'(MAX_WIDTH);
    end else begin
      eff_w = GEO_W'(image_width);
    end
    if (image_height == '0) begin
      eff_h = GEO_W'(1);
    end else if (image_height > GEO_W'(MAX_HEIGHT)) begin
      eff_h = GEO_W'(MAX_HEIGHT);
    end else begin
      eff_h = image_height;
    end
    w_last = eff_w - 1'b1;
    h_last = eff_h - 1'b1;
  end

  assign in_acc = in_valid && !in_stall;

  // Input side: a pixel after a finished frame starts the next frame at the origin.
  logic [ROW_W-1:0]  base_row;
  logic [COL_W-1:0]  base_col;
  logic [SLOT_W-1:0] base_slot;
  logic [GEO_W-1:0]  col_inc, row_inc;

  always_comb begin
    base_row  = in_done ? '0 : in_row;
    base_col  = in_done ? '0 : in_col;
    base_slot = in_done ? '0 : in_slot;
    col_inc   = GEO_W'(base_col) + 1'b1;
    row_inc   = GEO_W'(base_row) + 1'b1;
    ls_we     = in_acc && (in_data.mode == MODE_PIXEL);
    ls_waddr  = ls_addr(base_slot, base_col);
  end

  // Readiness of the next output and the bounds of its clipped window.
  logic [GEO_W-1:0]  nr_sum, nc_sum, nr, nc;
  logic [ROW_W-1:0]  r0, r_off;
  logic [COL_W-1:0]  c0;
  logic [SLOT_W-1:0] slot0;
  logic [SLOT_W:0]   slot_wide;

  always_comb begin
    nr_sum = GEO_W'(out_row) + GEO_W'(HALF_H);
    nc_sum = GEO_W'(out_col) + GEO_W'(HALF_W);
    nr     = (nr_sum > h_last) ? h_last : nr_sum;
    nc     = (nc_sum > w_last) ? w_last : nc_sum;
    ready  = in_done || (nr < GEO_W'(in_row)) ||
             ((nr == GEO_W'(in_row)) && (nc < GEO_W'(in_col)));
    r0     = (out_row >= ROW_W'(HALF_H)) ? out_row - ROW_W'(HALF_H) : '0;
    c0     = (GEO_W'(out_col) >= GEO_W'(HALF_W)) ? out_col - COL_W'(HALF_W) : '0;
    r_off  = out_row - r0;
    if ((SLOT_W + 1)'(out_slot) >= (SLOT_W + 1)'(r_off)) begin
      slot_wide = (SLOT_W + 1)'(out_slot) - (SLOT_W + 1)'(r_off);
    end else begin
      slot_wide = (SLOT_W + 1)'(out_slot) + (SLOT_W + 1)'(LS_ROWS) - (SLOT_W + 1)'(r_off);
    end
    slot0 = slot_wide[SLOT_W-1:0];
  end

  // Per-tap arithmetic.
  logic [OFF_W-1:0]  adr, adc;
  logic [PIX_W-1:0]  adiff;
  logic [D2_W-1:0]   dist2_c;
  logic [31:0]       wprod;
  logic [ACC_W-1:0]  acc_prod;
  logic [DEN_W:0]    shifted;
  logic              div_ge;
  logic [PIX_W-1:0]  res;

  always_comb begin
    adr      = (tr >= out_row) ? OFF_W'(tr - out_row) : OFF_W'(out_row - tr);
    adc      = (tc >= out_col) ? OFF_W'(tc - out_col) : OFF_W'(out_col - tc);
    dist2_c  = D2_W'(adr) * D2_W'(adr) + D2_W'(adc) * D2_W'(adc);
    adiff    = (ls_rdata >= center) ? ls_rdata - center : center - ls_rdata;
    ws_eff   = ((sprod >> (16 + ROM_AW)) != '0) ? '0 : ws_q;
    wr_eff   = ((rprod >> (16 + ROM_AW)) != '0) ? '0 : wr_q;
    wprod    = 32'(ws_eff) * 32'(wr_eff);
    acc_prod = ACC_W'(wt) * ACC_W'(nb);
    tap_last = (tr == r_last) && (tc == c_last);
    shifted  = {rem, dq[NUM_W-1]};
    div_ge   = shifted >= {1'b0, den};
    if (den == '0) begin
      res = center;
    end else if (dq > NUM_W'(255)) begin
      res = '1;
    end else begin
      res = dq[PIX_W-1:0];
    end
    can_load = !out_valid || !out_stall;
  end

  // Next state and handshake.
  always_comb begin
    state_next = state;
    in_stall   = (state != ST_IDLE);
    ls_raddr   = ls_addr(t_slot, tc);
    case (state)
      ST_IDLE:   if (in_acc) state_next = ST_CHECK;
      ST_CHECK:  state_next = ready ? ST_CREAD : ST_IDLE;
      ST_CREAD: begin
        ls_raddr   = ls_addr(out_slot, out_col);
        state_next = ST_CWAIT;
      end
      ST_CWAIT:  state_next = ST_TREAD;
      ST_TREAD:  state_next = ST_TSQ;
      ST_TSQ:    state_next = ST_TARG;
      ST_TARG:   state_next = ST_TROM;
      ST_TROM:   state_next = ST_TWT;
      ST_TWT:    state_next = ST_TACC;
      ST_TACC:   state_next = tap_last ? ST_DSTART : ST_TREAD;
      ST_DSTART: state_next = ST_DIV;
      ST_DIV:    if (dcnt == DCNT_W'(NUM_W - 1)) state_next = ST_LOAD;
      ST_LOAD:   if (can_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ls_we) begin
      ls_mem[ls_waddr] <= in_data.pixel;
    end
    ls_rdata <= ls_mem[ls_raddr];
  end

  // Two read ports on the exponential ROM: spatial and range argument.
  always_ff @(posedge clk) begin
    ws_q <= EXP_ROM[ROM_AW'(sprod >> 16)];
    wr_q <= EXP_ROM[ROM_AW'(rprod >> 16)];
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_CHECK: begin
        tr      <= r0;
        tc      <= c0;
        c_first <= c0;
        c_last  <= nc[COL_W-1:0];
        r_last  <= nr[ROW_W-1:0];
        t_slot  <= slot0;
        num     <= '0;
        den     <= '0;
      end
      ST_CWAIT: center <= ls_rdata;
      ST_TSQ: begin
        nb    <= ls_rdata;
        d2    <= (2 * PIX_W)'(adiff) * (2 * PIX_W)'(adiff);
        dist2 <= dist2_c;
      end
      ST_TARG: begin
        sprod <= SP_W'(spatial_scale) * SP_W'(dist2);
        rprod <= RP_W'(range_scale) * RP_W'(d2);
      end
      ST_TWT: wt <= wprod[31:16];
      ST_TACC: begin
        num <= num + NUM_W'(acc_prod);
        den <= den + DEN_W'(wt);
        if (tc == c_last) begin
          tc     <= c_first;
          tr     <= tr + 1'b1;
          t_slot <= slot_inc(t_slot);
        end else begin
          tc <= tc + 1'b1;
        end
      end
      ST_DSTART: begin
        dq   <= num + NUM_W'(den >> 1);
        rem  <= '0;
        dcnt <= '0;
      end
      ST_DIV: begin
        rem  <= div_ge ? DEN_W'(shifted - {1'b0, den}) : DEN_W'(shifted);
        dq   <= {dq[NUM_W-2:0], div_ge};
        dcnt <= dcnt + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      image_width   <= IMAGE_WIDTH_RST;
      image_height  <= IMAGE_HEIGHT_RST;
      spatial_scale <= SPATIAL_SCALE_RST;
      range_scale   <= RANGE_SCALE_RST;
      in_row        <= '0;
      in_col        <= '0;
      in_slot       <= '0;
      in_done       <= 1'b0;
      out_row       <= '0;
      out_col       <= '0;
      out_slot      <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: begin
            if (cfg_reg_t'(cfg_index) == REG_IMAGE_WIDTH) begin
              image_width <= cfg_data[IW_W-1:0];
            end else begin
              image_height <= cfg_data[GEO_W-1:0];
            end
            in_row   <= '0;
            in_col   <= '0;
            in_slot  <= '0;
            in_done  <= 1'b0;
            out_row  <= '0;
            out_col  <= '0;
            out_slot <= '0;
          end
          REG_SPATIAL_SCALE: spatial_scale <= cfg_data[SCALE_W-1:0];
          REG_RANGE_SCALE:   range_scale   <= cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end

      if (ls_we) begin
        if (in_done) begin
          out_row  <= '0;
          out_col  <= '0;
          out_slot <= '0;
        end
        if (col_inc >= eff_w) begin
          in_col <= '0;
          if (row_inc >= eff_h) begin
            in_row  <= '0;
            in_slot <= '0;
            in_done <= 1'b1;
          end else begin
            in_row  <= base_row + 1'b1;
            in_slot <= slot_inc(base_slot);
            in_done <= 1'b0;
          end
        end else begin
          in_row  <= base_row;
          in_slot <= base_slot;
          in_col  <= base_col + 1'b1;
          in_done <= 1'b0;
        end
      end

      if (state == ST_LOAD && can_load) begin
        out_valid             <= 1'b1;
        out_data.filtered     <= res;
        out_data.end_of_frame <= (GEO_W'(out_row) == h_last) && (GEO_W'(out_col) == w_last);
        if ((GEO_W'(out_row) == h_last) && (GEO_W'(out_col) == w_last)) begin
          out_row  <= '0;
          out_col  <= '0;
          out_slot <= '0;
          in_done  <= 1'b0;
        end else if (GEO_W'(out_col) + 1'b1 >= eff_w) begin
          out_col  <= '0;
          out_row  <= out_row + 1'b1;
          out_slot <= slot_inc(out_slot);
        end else begin
          out_col <= out_col + 1'b1;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // The centre tap alone weighs 65534, so the divisor can never be small.
  a_den_floor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DSTART) |-> (den >= DEN_W'(65534)))
    else $error("weight sum below centre tap weight");

  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == ST_CHECK))
    else $error("accepted beat not followed by readiness check");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD && can_load) |=> out_valid)
    else $error("finished result not presented");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TREAD) |-> (t_slot <= SLOT_W'(LS_ROWS - 1)))
    else $error("tap row slot out of range");
`endif

endmodule
